/* rtl/pce_pkg.sv */
// shared types and constants for the pearson correlation engine
`default_nettype none
package pce_pkg;
	localparam int SAMPLE_W   = 16;
	localparam int CORR_W     = 16;
	localparam int COUNT_W    = 11;
	localparam int FRAC_SHIFT = 32;
	localparam int DIV_STEPS  = FRAC_SHIFT + 1;
	localparam int SQRT_STEPS = 17;
	localparam int MIN_PAIRS  = 2;
	localparam logic signed [CORR_W-1:0] CORR_MAX = 16'sd32767;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FEW  = 2'd1,
		STAT_FLAT = 2'd2,
		STAT_OVF  = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [CORR_W-1:0] correlation;
		status_t                  status;
		logic [COUNT_W-1:0]       sample_count;
	} result_t;
endpackage
`default_nettype wire

/* rtl/pce_addsub.sv */
// wide adder/subtractor shared by the sequencer's multiply, division and root steps
`default_nettype none
module pce_addsub #(
	parameter int W = 64
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic         sub,
	output logic [W-1:0]      sum,
	output logic              carry
);
	logic [W:0] full;

	// carry high on subtract means a >= b
	assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
	assign sum   = full[W-1:0];
	assign carry = full[W];
endmodule
`default_nettype wire

/* rtl/pce_accum.sv */
// running sums of count, x, y, x*x, y*y and x*y
`default_nettype none
module pce_accum import pce_pkg::*; #(
	parameter int MAX_SAMPLES = 1024,
	parameter int NW          = 11
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       take,
	input  wire logic                       clear,
	input  wire logic signed [SAMPLE_W-1:0] x_sample,
	input  wire logic signed [SAMPLE_W-1:0] y_sample,
	output logic [NW-1:0]                   pair_count,
	output logic signed [NW+15:0]           sum_x,
	output logic signed [NW+15:0]           sum_y,
	output logic [NW+29:0]                  sum_xx,
	output logic [NW+29:0]                  sum_yy,
	output logic signed [NW+30:0]           sum_xy,
	output logic                            overflowed
);
	localparam int SUM_W = NW + 16;
	localparam int SQ_W  = NW + 30;
	localparam int XY_W  = NW + 31;

	logic signed [2*SAMPLE_W-1:0] pxx, pyy, pxy;
	logic [NW-1:0]                count_q;
	logic signed [SUM_W-1:0]      sx_q, sy_q;
	logic [SQ_W-1:0]              sxx_q, syy_q;
	logic signed [XY_W-1:0]       sxy_q;
	logic                         ovf_q;

	assign pxx = x_sample * x_sample;
	assign pyy = y_sample * y_sample;
	assign pxy = x_sample * y_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sxx_q   <= '0;
			syy_q   <= '0;
			sxy_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (clear) begin
			count_q <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sxx_q   <= '0;
			syy_q   <= '0;
			sxy_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			if (count_q == NW'(MAX_SAMPLES)) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + NW'(1);
				sx_q    <= sx_q + SUM_W'(x_sample);
				sy_q    <= sy_q + SUM_W'(y_sample);
				sxx_q   <= sxx_q + SQ_W'($unsigned(pxx));
				syy_q   <= syy_q + SQ_W'($unsigned(pyy));
				sxy_q   <= sxy_q + XY_W'(pxy);
			end
		end
	end

	assign pair_count = count_q;
	assign sum_x      = sx_q;
	assign sum_y      = sy_q;
	assign sum_xx     = sxx_q;
	assign sum_yy     = syy_q;
	assign sum_xy     = sxy_q;
	assign overflowed = ovf_q;
endmodule
`default_nettype wire

/* rtl/pce_seq.sv */
// sequencer: variances, covariance, exact division and square root on one adder
`default_nettype none
module pce_seq import pce_pkg::*; #(
	parameter int NW = 11
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [NW-1:0]        pair_count,
	input  wire logic signed [NW+15:0] sum_x,
	input  wire logic signed [NW+15:0] sum_y,
	input  wire logic [NW+29:0]       sum_xx,
	input  wire logic [NW+29:0]       sum_yy,
	input  wire logic signed [NW+30:0] sum_xy,
	input  wire logic                 overflowed,
	input  wire logic                 out_free,
	output logic                      idle,
	output logic                      done,
	output result_t                   result
);
	localparam int SUM_W  = NW + 16;
	localparam int VW     = 2 * NW + 30;
	localparam int WW     = 2 * VW + FRAC_SHIFT + 1;
	localparam int QB_W   = 2 * SQRT_STEPS;
	localparam int ROOT_W = SQRT_STEPS;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PREP = 6'b000010,
		S_MUL  = 6'b000100,
		S_DIV  = 6'b001000,
		S_SQRT = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	typedef enum logic [7:0] {
		M_NSXX  = 8'b00000001,
		M_SXSQ  = 8'b00000010,
		M_NSYY  = 8'b00000100,
		M_SYSQ  = 8'b00001000,
		M_NSXY  = 8'b00010000,
		M_SXSY  = 8'b00100000,
		M_VXVY  = 8'b01000000,
		M_COVSQ = 8'b10000000
	} mulop_t;

	state_t              state_q;
	mulop_t              op_q;
	status_t             status_q;
	logic [WW-1:0]       acc_q, ma_q, d_q;
	logic [VW-1:0]       mb_q, vx_q, vy_q, cmag_q;
	logic                neg_q;
	logic [QB_W-1:0]     qbits_q;
	logic [ROOT_W-1:0]   s_q;
	logic [5:0]          step_q;

	logic                sx_neg, sy_neg;
	logic [SUM_W-1:0]    sx_mag, sy_mag;
	logic [VW-1:0]       acc_lo_neg, cov_mag;
	logic                mul_sub;
	logic [WW-1:0]       add_a, add_b, add_sum, sqrt_rem;
	logic                add_sub, add_carry;
	logic [ROOT_W:0]     m_round;
	logic signed [CORR_W-1:0] corr;

	assign sx_neg     = sum_x[SUM_W-1];
	assign sy_neg     = sum_y[SUM_W-1];
	assign sx_mag     = sx_neg ? (~sum_x + SUM_W'(1)) : sum_x;
	assign sy_mag     = sy_neg ? (~sum_y + SUM_W'(1)) : sum_y;
	assign acc_lo_neg = ~acc_q[VW-1:0] + VW'(1);
	assign cov_mag    = acc_q[WW-1] ? acc_lo_neg : acc_q[VW-1:0];
	assign sqrt_rem   = {acc_q[WW-3:0], qbits_q[QB_W-1 -: 2]};

	// sx*sy enters as sy*|sx|, so its sign flips the operation
	always_comb begin
		case (op_q)
			M_SXSQ, M_SYSQ: mul_sub = 1'b1;
			M_SXSY:         mul_sub = ~sx_neg;
			default:        mul_sub = 1'b0;
		endcase
	end

	always_comb begin
		add_a   = acc_q;
		add_b   = ma_q;
		add_sub = 1'b0;
		case (state_q)
			S_MUL: begin
				add_sub = mul_sub;
			end
			S_DIV: begin
				add_b   = d_q;
				add_sub = 1'b1;
			end
			S_SQRT: begin
				add_a   = sqrt_rem;
				add_b   = WW'({s_q, 2'b01});
				add_sub = 1'b1;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	pce_addsub #(.W(WW)) u_addsub (
		.a     (add_a),
		.b     (add_b),
		.sub   (add_sub),
		.sum   (add_sum),
		.carry (add_carry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= M_NSXX;
			status_q <= STAT_OK;
			step_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_PREP;
				end
				S_PREP: begin
					if (overflowed) begin
						status_q <= STAT_OVF;
						state_q  <= S_DONE;
					end else if (pair_count < NW'(MIN_PAIRS)) begin
						status_q <= STAT_FEW;
						state_q  <= S_DONE;
					end else begin
						status_q <= STAT_OK;
						op_q     <= M_NSXX;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					if (mb_q == '0) begin
						case (op_q)
							M_NSXX: op_q <= M_SXSQ;
							M_SXSQ: op_q <= M_NSYY;
							M_NSYY: op_q <= M_SYSQ;
							M_SYSQ: begin
								if (vx_q == '0 || acc_q[VW-1:0] == '0) begin
									status_q <= STAT_FLAT;
									state_q  <= S_DONE;
								end else begin
									op_q <= M_NSXY;
								end
							end
							M_NSXY: op_q <= M_SXSY;
							M_SXSY: op_q <= M_VXVY;
							M_VXVY: op_q <= M_COVSQ;
							M_COVSQ: begin
								state_q <= S_DIV;
								step_q  <= '0;
							end
							default: op_q <= M_NSXX;
						endcase
					end
				end
				S_DIV: begin
					if (step_q == 6'(DIV_STEPS - 1)) begin
						state_q <= S_SQRT;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				S_SQRT: begin
					if (step_q == 6'(SQRT_STEPS - 1)) begin
						state_q <= S_DONE;
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, loaded per phase
	always_ff @(posedge clk) begin
		case (state_q)
			S_PREP: begin
				acc_q <= '0;
				ma_q  <= WW'(sum_xx);
				mb_q  <= VW'(pair_count);
			end
			S_MUL: begin
				if (mb_q != '0) begin
					if (mb_q[0]) acc_q <= add_sum;
					ma_q <= ma_q << 1;
					mb_q <= mb_q >> 1;
				end else begin
					case (op_q)
						M_NSXX: begin
							ma_q <= WW'(sx_mag);
							mb_q <= VW'(sx_mag);
						end
						M_SXSQ: begin
							vx_q  <= acc_q[VW-1:0];
							acc_q <= '0;
							ma_q  <= WW'(sum_yy);
							mb_q  <= VW'(pair_count);
						end
						M_NSYY: begin
							ma_q <= WW'(sy_mag);
							mb_q <= VW'(sy_mag);
						end
						M_SYSQ: begin
							vy_q  <= acc_q[VW-1:0];
							acc_q <= '0;
							ma_q  <= WW'(sum_xy);
							mb_q  <= VW'(pair_count);
						end
						M_NSXY: begin
							ma_q <= WW'(sum_y);
							mb_q <= VW'(sx_mag);
						end
						M_SXSY: begin
							neg_q  <= acc_q[WW-1];
							cmag_q <= cov_mag;
							acc_q  <= '0;
							ma_q   <= WW'(vx_q);
							mb_q   <= vy_q;
						end
						M_VXVY: begin
							d_q   <= acc_q << FRAC_SHIFT;
							acc_q <= '0;
							ma_q  <= WW'(cmag_q);
							mb_q  <= cmag_q;
						end
						M_COVSQ: begin
							acc_q   <= acc_q << FRAC_SHIFT;
							qbits_q <= '0;
						end
						default: begin
							acc_q <= '0;
						end
					endcase
				end
			end
			S_DIV: begin
				// the root starts from an empty remainder
				if (step_q == 6'(DIV_STEPS - 1)) begin
					acc_q <= '0;
					s_q   <= '0;
				end else if (add_carry) begin
					acc_q <= add_sum;
				end
				qbits_q <= {qbits_q[QB_W-2:0], add_carry};
				d_q     <= d_q >> 1;
			end
			S_SQRT: begin
				acc_q   <= add_carry ? add_sum : sqrt_rem;
				s_q     <= {s_q[ROOT_W-2:0], add_carry};
				qbits_q <= qbits_q << 2;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// round half away from zero: m = (root + 1) / 2
	assign m_round = ({1'b0, s_q} + (ROOT_W + 1)'(1)) >> 1;

	always_comb begin
		if (status_q != STAT_OK) begin
			corr = '0;
		end else if (neg_q) begin
			corr = CORR_W'(~m_round + (ROOT_W + 1)'(1));
		end else if (m_round > (ROOT_W + 1)'(CORR_MAX)) begin
			corr = CORR_MAX;
		end else begin
			corr = CORR_W'(m_round);
		end
	end

	assign idle                = (state_q == S_IDLE);
	assign done                = (state_q == S_DONE) && out_free;
	assign result.correlation  = corr;
	assign result.status       = status_q;
	assign result.sample_count = COUNT_W'(pair_count);

`ifndef SYNTHESIS
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (step_q < 6'(DIV_STEPS)))
		else $error("division step count out of range");
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STAT_OK) |-> (result.correlation == '0))
		else $error("nonzero correlation with fault status");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle after result");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == S_IDLE))
		else $error("set closed while sequencer busy");
`endif
endmodule
`default_nettype wire

/* rtl/pearson_correlation_engine.sv */
// top level: sample stream in, one pearson coefficient out per set
//
// channel  dir  tdata                                       tuser        tlast
// s_*      in   [15:0] x_sample, [31:16] y_sample           -            last
// m_*      out  [15:0] correlation, [26:16] sample_count    [1:0] status -
//
// a pair without tlast is accumulated and leaves s_tready high for the next pair
// a pair with tlast holds s_tready low while the shared adder runs: a prepare state,
// eight shift-and-add products (four if a variance is zero) each followed by a load step,
// 33 division steps and 17 root steps, then a result state
// the result waits in the output register; the sequencer stalls only if it is full
// arst_n clears all sums, the sequencer and the output valid
`default_nettype none
module pearson_correlation_engine import pce_pkg::*; #(
	parameter int MAX_SAMPLES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // x_sample, y_sample
	input  wire logic        s_tlast,  // last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // correlation, sample_count, zero pad
	output logic [1:0]       m_tuser   // status
);
	localparam int NW = $clog2(MAX_SAMPLES + 1);

	logic                      take, idle, done, out_free;
	logic [NW-1:0]             pair_count;
	logic signed [NW+15:0]     sum_x, sum_y;
	logic [NW+29:0]            sum_xx, sum_yy;
	logic signed [NW+30:0]     sum_xy;
	logic                      overflowed;
	result_t                   result, res_q;
	logic                      m_valid_q;

	assign s_tready = idle;
	assign take     = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	pce_accum #(.MAX_SAMPLES(MAX_SAMPLES), .NW(NW)) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.clear      (done),
		.x_sample   (s_tdata[15:0]),
		.y_sample   (s_tdata[31:16]),
		.pair_count (pair_count),
		.sum_x      (sum_x),
		.sum_y      (sum_y),
		.sum_xx     (sum_xx),
		.sum_yy     (sum_yy),
		.sum_xy     (sum_xy),
		.overflowed (overflowed)
	);

	pce_seq #(.NW(NW)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (take && s_tlast),
		.pair_count (pair_count),
		.sum_x      (sum_x),
		.sum_y      (sum_y),
		.sum_xx     (sum_xx),
		.sum_yy     (sum_yy),
		.sum_xy     (sum_xy),
		.overflowed (overflowed),
		.out_free   (out_free),
		.idle       (idle),
		.done       (done),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (done) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) res_q <= result;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, res_q.sample_count, res_q.correlation};
	assign m_tuser  = res_q.status;
endmodule
`default_nettype wire
